[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPL(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/isre_pkg.sv]
package isre_pkg;

  // default run limits
  localparam int DEF_MAX_SOLID   = 127;
  localparam int DEF_MAX_LITERAL = 127;

  // encoded bytes per output beat
  localparam int BEAT_BYTES = 8;

  // byte values with special meaning
  localparam logic [7:0] BYTE_ZEROS = 8'h00;
  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] LIT_MARK   = 8'h80;

  // kind of the open run
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_SOLID   = 2'd1,
    KIND_LITERAL = 2'd2
  } kind_t;

endpackage

[hw/rtl/img_scanline_run_encoder.sv]
// channel  dir  tdata                                   tlast      tuser
// s_*      in   [7:0] data_byte                         line_end   -
// m_*      out  [63:0] packed_bytes, [67:64] byte_count line_done  last_result
//
// an input beat is taken while the encoder is idle; a beat that closes runs then
// holds off the input for ceil(encoded bytes / 8) output beats, since the
// literal memory (64-bit rows) delivers one row per output beat.
// rst is synchronous and clears the run state and the output valid; the literal
// memory is not cleared, only bytes of the open run are ever read.
// the output register holds a stalled beat; emission pauses until it is taken.
`include "assert_macros.svh"

module img_scanline_run_encoder #(
  parameter int MAX_SOLID   = isre_pkg::DEF_MAX_SOLID,
  parameter int MAX_LITERAL = isre_pkg::DEF_MAX_LITERAL
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [63:0] packed_bytes, [67:64] byte_count, rest zero
  output logic        m_tlast,
  output logic        m_tuser    // [0] last_result
);
  import isre_pkg::*;

  localparam int MAX_LEN = (MAX_SOLID > MAX_LITERAL) ? MAX_SOLID : MAX_LITERAL;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ROWS    = (MAX_LITERAL + BEAT_BYTES - 1) / BEAT_BYTES;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TOT_W   = ($clog2(MAX_LITERAL + 6) > 4) ? $clog2(MAX_LITERAL + 6) : 4;
  localparam int BK_W    = TOT_W - 3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t           state;
  kind_t            run_kind;
  logic             solid_value;
  logic [LEN_W-1:0] run_length;

  // literal memory, eight bytes per row
  logic [63:0]      mem [ROWS];
  logic [63:0]      mem_q;
  logic [15:0]      prev_hi;

  // emission plan of the current item
  logic [7:0]       p_bytes [4];
  logic [2:0]       plen;
  logic [LEN_W-1:0] lit_n;
  logic [7:0]       t_bytes [3];
  logic [1:0]       tlen;
  logic [TOT_W-1:0] total;
  logic             end_r;
  logic [BK_W-1:0]  bk;

  // output register
  logic [63:0]      out_packed;
  logic [3:0]       out_cnt;
  logic             out_last;
  logic             out_done;

  // step decode
  logic             accept;
  logic [7:0]       in_byte;
  logic             is_solid;
  logic             in_val;
  logic             cont;
  logic             close_old;
  logic             close_new;
  logic [LEN_W-1:0] new_len;
  logic [7:0]       code1;
  logic [7:0]       code2;
  logic             seg1_lit;
  logic             seg1_sol;
  logic             seg2_cont;
  logic [7:0]       s2arr [3];
  logic [1:0]       s2len;
  logic [7:0]       d_p [4];
  logic [2:0]       d_plen;
  logic [LEN_W-1:0] d_n;
  logic [7:0]       d_t [3];
  logic [1:0]       d_tlen;
  logic [TOT_W-1:0] d_total;
  kind_t            kind_next;
  logic [LEN_W-1:0] length_next;
  logic             mem_we;
  logic [LEN_W-1:0] wr_pos;
  logic [ROW_W-1:0] wr_row;
  logic [2:0]       wr_lane;

  // beat assembly
  logic             load;
  logic [TOT_W-1:0] base;
  logic [TOT_W-1:0] remaining;
  logic             beat_last;
  logic [3:0]       beat_cnt;
  logic [TOT_W-1:0] pn;
  logic [TOT_W-1:0] lane_pos [BEAT_BYTES];
  logic [TOT_W-1:0] lane_tidx [BEAT_BYTES];
  logic [63:0]      mem_win;
  logic [63:0]      beat_data;
  logic [BK_W-1:0]  rd_idx;
  logic [ROW_W-1:0] rd_row;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // run decisions for the incoming byte
  always_comb begin
    in_byte  = s_tdata;
    is_solid = (in_byte == BYTE_ZEROS) || (in_byte == BYTE_ONES);
    in_val   = in_byte[7];
    if (is_solid) begin
      cont = (run_kind == KIND_SOLID) && (solid_value == in_val) && (run_length < MAX_SOLID);
    end else begin
      cont = (run_kind == KIND_LITERAL) && (run_length < MAX_LITERAL);
    end
    close_old = !cont && (run_kind != KIND_NONE);
    new_len   = cont ? LEN_W'(run_length + 1'b1) : LEN_W'(1);
    close_new = s_tlast || (is_solid ? (new_len >= MAX_SOLID) : (new_len >= MAX_LITERAL));
    code1     = {solid_value, 7'(run_length)};
    code2     = {in_val, 7'(new_len)};
    seg1_lit  = close_old && (run_kind == KIND_LITERAL);
    seg1_sol  = close_old && (run_kind == KIND_SOLID);
    seg2_cont = close_new && !is_solid && cont;

    // bytes of a solid run, or of a freshly started literal run, that closes at once
    s2arr = '{8'h00, 8'h00, 8'h00};
    s2len = 2'd0;
    if (close_new && is_solid) begin
      s2arr[0] = code2;
      s2len    = 2'd1;
    end else if (close_new && !cont) begin
      s2arr = '{LIT_MARK, 8'd1, in_byte};
      s2len = 2'd3;
    end

    // prefix, stored literals, trailer
    if (seg1_lit || seg2_cont) begin
      d_p    = '{LIT_MARK, seg1_lit ? 8'(run_length) : 8'(new_len), 8'h00, 8'h00};
      d_plen = 3'd2;
      d_n    = run_length;
      if (seg1_lit) begin
        d_t    = s2arr;
        d_tlen = s2len;
      end else begin
        d_t    = '{in_byte, 8'h00, 8'h00};
        d_tlen = 2'd1;
      end
    end else if (seg1_sol) begin
      d_p    = '{code1, s2arr[0], s2arr[1], s2arr[2]};
      d_plen = 3'(s2len) + 3'd1;
      d_n    = '0;
      d_t    = '{8'h00, 8'h00, 8'h00};
      d_tlen = 2'd0;
    end else begin
      d_p    = '{s2arr[0], s2arr[1], s2arr[2], 8'h00};
      d_plen = {1'b0, s2len};
      d_n    = '0;
      d_t    = '{8'h00, 8'h00, 8'h00};
      d_tlen = 2'd0;
    end
    d_total = TOT_W'(d_plen) + TOT_W'(d_n) + TOT_W'(d_tlen);

    // run state after the byte
    if (close_new) begin
      kind_next   = KIND_NONE;
      length_next = '0;
    end else begin
      kind_next   = is_solid ? KIND_SOLID : KIND_LITERAL;
      length_next = new_len;
    end

    // literal byte goes to the store while its run stays open
    mem_we  = accept && !is_solid && !close_new;
    wr_pos  = cont ? run_length : '0;
    wr_row  = ROW_W'(wr_pos >> 3);
    wr_lane = 3'(wr_pos);
  end

  // beat assembly from prefix, memory rows and trailer
  always_comb begin
    load      = (state == ST_EMIT) && (!m_tvalid || m_tready);
    base      = {bk, 3'b000};
    remaining = total - base;
    beat_last = (remaining <= TOT_W'(BEAT_BYTES));
    beat_cnt  = beat_last ? 4'(remaining) : 4'(BEAT_BYTES);
    pn        = TOT_W'(plen) + TOT_W'(lit_n);
    mem_win   = {mem_q[47:0], prev_hi};
    for (int j = 0; j < BEAT_BYTES; j++) begin
      lane_pos[j]  = base + TOT_W'(j);
      lane_tidx[j] = lane_pos[j] - pn;
      if (lane_pos[j] < TOT_W'(plen)) begin
        beat_data[j*8 +: 8] = p_bytes[lane_pos[j][1:0]];
      end else if (lane_pos[j] < pn) begin
        beat_data[j*8 +: 8] = mem_win[j*8 +: 8];
      end else if (lane_pos[j] < total) begin
        beat_data[j*8 +: 8] = t_bytes[lane_tidx[j][1:0]];
      end else begin
        beat_data[j*8 +: 8] = 8'h00;
      end
    end

    // row for the next beat, fetched while the current beat is loaded
    if (state == ST_EMIT) begin
      rd_idx = load ? BK_W'(bk + 1'b1) : bk;
    end else begin
      rd_idx = '0;
    end
    rd_row = (rd_idx < ROWS) ? ROW_W'(rd_idx) : '0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      run_kind    <= KIND_NONE;
      solid_value <= 1'b0;
      run_length  <= '0;
      bk          <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        run_kind    <= kind_next;
        run_length  <= length_next;
        solid_value <= is_solid ? in_val : solid_value;
        bk          <= '0;
        if (d_total != '0) begin
          state <= ST_EMIT;
        end
      end
      if (load) begin
        if (beat_last) begin
          state <= ST_IDLE;
        end else begin
          bk <= BK_W'(bk + 1'b1);
        end
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // plan and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      p_bytes <= d_p;
      plen    <= d_plen;
      lit_n   <= d_n;
      t_bytes <= d_t;
      tlen    <= d_tlen;
      total   <= d_total;
      end_r   <= s_tlast;
    end
    if (load) begin
      out_packed <= beat_data;
      out_cnt    <= beat_cnt;
      out_last   <= beat_last;
      out_done   <= beat_last && end_r;
      prev_hi    <= mem_q[63:48];
    end
  end

  // literal memory: one byte write, one registered row read
  always_ff @(posedge clk) begin
    mem_q <= mem[rd_row];
    if (mem_we) begin
      mem[wr_row][wr_lane*8 +: 8] <= in_byte;
    end
  end

  assign m_tdata = {4'b0000, out_cnt, out_packed};
  assign m_tlast = out_done;
  assign m_tuser = out_last;

  // checks
  `ASSERT_IMPL(a_solid_len, clk, rst, run_kind == KIND_SOLID, run_length < MAX_SOLID)
  `ASSERT_IMPL(a_lit_len, clk, rst, run_kind == KIND_LITERAL, (run_length < MAX_LITERAL) && (run_length != '0))
  `ASSERT_NEXT(a_last_idle, clk, rst, load && beat_last, s_tready && m_tvalid && m_tuser)
  `ASSERT_IMPL(a_done_last, clk, rst, m_tvalid && m_tlast, m_tuser && (tlen <= 2'd3))

endmodule
